// ----- rtl/core/nws_pkg.sv -----
package nws_pkg;

    localparam int DATA_W         = 16;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int ACC_W          = 40;
    localparam int CNT_W          = 11;
    localparam int VAL_W          = 9;
    localparam int MAX_FAN_IN     = 1024;
    localparam int FAN_IN_RESET   = 16;
    localparam int SIG_TABLE_BITS = 10;
    localparam int SIG_TABLE_SIZE = 1 << SIG_TABLE_BITS;
    // pre-activation window [-8, 8) in Q16.16 spans 20 bits
    localparam int SIG_SPAN_W     = 20;

    typedef logic [VAL_W-1:0] t_sig_table [SIG_TABLE_SIZE];

    // finished neuron handed from the accumulator to the output stage
    typedef struct packed {
        logic                    valid;
        logic                    size_error;
        logic signed [ACC_W-1:0] sum;
    } t_res;

    // restoring long division, evaluated only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], num[k]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [VAL_W-1:0] sig_entry(input int unsigned i);
        logic [63:0] mid;
        logic [63:0] mag;
        logic [63:0] y;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] p;
        logic        neg;
        mid = 64'(2 * i + 1);
        neg = mid < 64'(SIG_TABLE_SIZE);
        mag = neg ? 64'(SIG_TABLE_SIZE) - mid : mid - 64'(SIG_TABLE_SIZE);
        y   = mag << (25 - SIG_TABLE_BITS);
        t2  = (y * y) >> 30;
        t3  = (t2 * y) >> 30;
        t4  = (t3 * y) >> 30;
        // truncated series for exp(-|x|/256), then squared eight times
        e   = (64'd1 << 30) - y + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
        for (int k = 0; k < 8; k++) begin
            e = (e * e) >> 30;
        end
        den = (64'd1 << 30) + e;
        p   = div_u64((64'd256 << 30) + den / 64'd2, den);
        if (p > 64'd256) begin
            p = 64'd256;
        end
        return neg ? VAL_W'(64'd256 - p) : VAL_W'(p);
    endfunction

    function automatic t_sig_table sig_table_build();
        t_sig_table t;
        for (int unsigned i = 0; i < SIG_TABLE_SIZE; i++) begin
            t[i] = sig_entry(i);
        end
        return t;
    endfunction

endpackage

// ----- rtl/core/nws_mac.sv -----
module nws_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [nws_pkg::DATA_W-1:0]    i_weight,
    input  logic signed [nws_pkg::DATA_W-1:0]    i_activation,
    input  logic                                 i_is_bias,
    input  logic                                 i_is_last,
    input  logic        [nws_pkg::CNT_W-1:0]     i_fan_in,
    input  logic                                 i_res_ready,
    output nws_pkg::t_res                        o_res
);

    // stage 1: input register
    logic                                r_s1_valid;
    logic signed [nws_pkg::DATA_W-1:0]   r_s1_weight;
    logic signed [nws_pkg::DATA_W-1:0]   r_s1_act;
    logic                                r_s1_bias;
    logic                                r_s1_last;
    // stage 2: product register
    logic                                r_s2_valid;
    logic signed [nws_pkg::PROD_W-1:0]   r_s2_prod;
    logic                                r_s2_bias;
    logic                                r_s2_last;
    // running neuron state
    logic signed [nws_pkg::ACC_W-1:0]    r_acc;
    logic        [nws_pkg::CNT_W-1:0]    r_cnt;
    // stage 3: finished sum waiting for the output stage
    logic                                r_s3_valid;
    logic                                r_s3_err;
    logic signed [nws_pkg::ACC_W-1:0]    r_s3_sum;

    logic                                s3_free;
    logic                                s2_move;
    logic                                s1_move;
    logic signed [nws_pkg::PROD_W-1:0]   n_prod;
    logic signed [nws_pkg::ACC_W:0]      acc_sum;
    logic signed [nws_pkg::ACC_W-1:0]    n_acc;
    logic        [nws_pkg::CNT_W-1:0]    n_cnt;

    // only items that end a neuron need room downstream
    assign s3_free = !r_s3_valid || i_res_ready;
    assign s2_move = r_s2_valid && (!r_s2_last || s3_free);
    assign s1_move = r_s1_valid && (!r_s2_valid || s2_move);
    assign o_ready = !r_s1_valid || s1_move;

    // bias enters as Q16.16 through the same register as the product
    assign n_prod = r_s1_bias
        ? $signed({{(nws_pkg::PROD_W - nws_pkg::DATA_W - 8){r_s1_weight[nws_pkg::DATA_W-1]}},
                   r_s1_weight, 8'b0})
        : r_s1_weight * r_s1_act;

    assign acc_sum = {r_acc[nws_pkg::ACC_W-1], r_acc}
        + {{(nws_pkg::ACC_W + 1 - nws_pkg::PROD_W){r_s2_prod[nws_pkg::PROD_W-1]}}, r_s2_prod};

    always_comb begin
        if (r_s2_bias) begin
            n_acc = {{(nws_pkg::ACC_W - nws_pkg::PROD_W){r_s2_prod[nws_pkg::PROD_W-1]}},
                     r_s2_prod};
            n_cnt = '0;
        end else begin
            if (acc_sum[nws_pkg::ACC_W] != acc_sum[nws_pkg::ACC_W-1]) begin
                n_acc = acc_sum[nws_pkg::ACC_W]
                    ? {1'b1, {(nws_pkg::ACC_W-1){1'b0}}}
                    : {1'b0, {(nws_pkg::ACC_W-1){1'b1}}};
            end else begin
                n_acc = acc_sum[nws_pkg::ACC_W-1:0];
            end
            n_cnt = (&r_cnt) ? r_cnt : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_acc      <= '0;
            r_cnt      <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (!r_s2_valid || s2_move) begin
                r_s2_valid <= s1_move;
            end
            if (s3_free) begin
                r_s3_valid <= s2_move && r_s2_last;
            end
            if (s2_move) begin
                if (r_s2_last) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_weight <= i_weight;
            r_s1_act    <= i_activation;
            r_s1_bias   <= i_is_bias;
            r_s1_last   <= i_is_last;
        end
        if (s1_move) begin
            r_s2_prod <= n_prod;
            r_s2_bias <= r_s1_bias;
            r_s2_last <= r_s1_last;
        end
        if (s2_move && r_s2_last && s3_free) begin
            r_s3_sum <= n_acc;
            r_s3_err <= n_cnt != i_fan_in;
        end
    end

    assign o_res.valid      = r_s3_valid;
    assign o_res.size_error = r_s3_err;
    assign o_res.sum        = r_s3_sum;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_move && r_s2_last |=> r_acc == '0 && r_cnt == '0)
        else $error("neuron state not cleared after final item");

    a_bias_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_move && r_s2_bias && !r_s2_last |=> r_cnt == '0)
        else $error("bias item did not restart the input count");

    a_s3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid && !i_res_ready |=> r_s3_valid && $stable(r_s3_sum) && $stable(r_s3_err))
        else $error("finished sum lost while output stage was full");

    a_last_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_move && r_s2_last |-> s3_free)
        else $error("final item left stage 2 without room downstream");

endmodule

// ----- rtl/core/nws_sig_rom.sv -----
module nws_sig_rom (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [nws_pkg::SIG_TABLE_BITS-1:0]   i_addr,
    output logic [nws_pkg::VAL_W-1:0]            o_data
);

    localparam nws_pkg::t_sig_table SigRom = nws_pkg::sig_table_build();

    logic [nws_pkg::VAL_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SigRom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/neuron_weighted_sum_sigmoid.sv -----
// Single neuron: bias plus weighted sum of Q8.8 inputs, then a table sigmoid.
// Input channel (i_valid / o_ready): a run starts with an item that has
// i_is_bias set (i_weight is the bias), followed by one item per input with
// i_weight and i_activation; the item with i_is_last set closes the run.
// Output channel (o_valid / i_ready): one transfer per closed run with the
// Q1.8 sigmoid in o_neuron_value (256 = 1.0), or 0 with o_size_error set if
// the weighted input count differs from the fan-in register.
// i_cfg_we / i_cfg_data write the fan-in; values above 1024 store as 1024.
// Throughput: one item per cycle while o_ready stays high. The multiply and the
// 40-bit saturating accumulate sit in separate stages; the accumulator feeds back
// onto itself once per item, which sets that rate.
// After its transfer the final item passes the input register, the product
// register, the accumulate stage and the sigmoid table read before o_valid rises.
// Reset clears the pipeline, accumulator and count, and sets fan-in to 16.
// When the receiver stalls, the result is held in the output register and
// items that do not end a run keep streaming in; a second finished run waits
// one stage back, and o_ready drops once a third final item is stuck behind
// it with the input register full.
module neuron_weighted_sum_sigmoid (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [nws_pkg::DATA_W-1:0]    i_weight,
    input  logic signed [nws_pkg::DATA_W-1:0]    i_activation,
    input  logic                                 i_is_bias,
    input  logic                                 i_is_last,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic        [nws_pkg::VAL_W-1:0]     o_neuron_value,
    output logic                                 o_size_error,
    input  logic                                 i_cfg_we,
    input  logic        [nws_pkg::CNT_W-1:0]     i_cfg_data
);

    logic [nws_pkg::CNT_W-1:0]          r_fan_in;
    logic [nws_pkg::CNT_W-1:0]          n_fan_in;
    logic                               r_out_valid;
    logic                               r_out_err;
    logic                               out_free;
    logic                               out_load;
    nws_pkg::t_res                      res;
    logic                               in_range;
    logic [nws_pkg::SIG_SPAN_W-1:0]     biased;
    logic [nws_pkg::SIG_TABLE_BITS-1:0] sig_addr;
    logic [nws_pkg::VAL_W-1:0]          sig_data;

    assign n_fan_in = (i_cfg_data > nws_pkg::CNT_W'(nws_pkg::MAX_FAN_IN))
        ? nws_pkg::CNT_W'(nws_pkg::MAX_FAN_IN) : i_cfg_data;

    assign out_free = !r_out_valid || i_ready;
    assign out_load = out_free && res.valid;

    nws_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_weight     (i_weight),
        .i_activation (i_activation),
        .i_is_bias    (i_is_bias),
        .i_is_last    (i_is_last),
        .i_fan_in     (r_fan_in),
        .i_res_ready  (out_free),
        .o_res        (res)
    );

    // saturate to [-8, 8): sum fits when bits above the window match its sign
    assign in_range = (&res.sum[nws_pkg::ACC_W-1:nws_pkg::SIG_SPAN_W-1])
                   || !(|res.sum[nws_pkg::ACC_W-1:nws_pkg::SIG_SPAN_W-1]);
    assign biased   = {~res.sum[nws_pkg::SIG_SPAN_W-1], res.sum[nws_pkg::SIG_SPAN_W-2:0]};

    always_comb begin
        if (in_range) begin
            sig_addr = biased[nws_pkg::SIG_SPAN_W-1 -: nws_pkg::SIG_TABLE_BITS];
        end else if (res.sum[nws_pkg::ACC_W-1]) begin
            sig_addr = '0;
        end else begin
            sig_addr = '1;
        end
    end

    nws_sig_rom u_sig_rom (
        .i_clk  (i_clk),
        .i_en   (out_load),
        .i_addr (sig_addr),
        .o_data (sig_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_in    <= nws_pkg::CNT_W'(nws_pkg::FAN_IN_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fan_in <= n_fan_in;
            end
            if (out_free) begin
                r_out_valid <= res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_err <= res.size_error;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_size_error   = r_out_err;
    assign o_neuron_value = r_out_err ? '0 : sig_data;

endmodule

// ----- sim/neuron_weighted_sum_sigmoid_test.sv -----
`timescale 1ns / 100ps

module neuron_weighted_sum_sigmoid_test;

    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     STALL_LEN   = 400;
    localparam longint ACC_HI      = 64'sd549755813887;
    localparam longint ACC_LO      = -ACC_HI - 1;
    localparam longint WINDOW      = 64'sd524288;   // 8.0 in Q16.16
    localparam int     COUNT_CAP   = 2047;
    localparam int     PHASE_ITEMS = 20;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_POS_PEAK, FILL_NEG_PEAK} t_fill;

    typedef struct {
        logic [nws_pkg::VAL_W-1:0] value;
        logic                      size_error;
    } t_neuron_out;

    // bias + weighted sum + table sigmoid, one entry queued per closed run
    class t_neuron_sum_model;
        logic [nws_pkg::VAL_W-1:0] sig_lut [1024];
        longint                    acc;
        int                        count;
        int                        fan_in;
        t_neuron_out               pending_outputs [$];
        int                        errors;

        function new();
            longint          mid;
            longint unsigned mag;
            longint unsigned y;
            longint unsigned t2;
            longint unsigned t3;
            longint unsigned t4;
            longint unsigned e;
            longint unsigned den;
            longint unsigned p;
            for (int i = 0; i < 1024; i++) begin
                mid = 2 * i + 1 - 1024;
                mag = (mid < 0) ? -mid : mid;
                y   = mag << 15;
                t2  = (y * y) >> 30;
                t3  = (t2 * y) >> 30;
                t4  = (t3 * y) >> 30;
                e   = (64'd1 << 30) - y + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
                for (int k = 0; k < 8; k++) begin
                    e = (e * e) >> 30;
                end
                den = (64'd1 << 30) + e;
                p   = ((64'd256 << 30) + den / 64'd2) / den;
                if (p > 64'd256) begin
                    p = 64'd256;
                end
                sig_lut[i] = (mid < 0) ? 9'(64'd256 - p) : 9'(p);
            end
            acc    = 0;
            count  = 0;
            fan_in = nws_pkg::FAN_IN_RESET;
            errors = 0;
        endfunction

        function void set_fan_in(logic [nws_pkg::CNT_W-1:0] v);
            fan_in = (v > nws_pkg::MAX_FAN_IN) ? nws_pkg::MAX_FAN_IN : int'(v);
        endfunction

        function void add_item(logic signed [15:0] w, logic signed [15:0] a,
                               logic is_bias, logic is_last);
            longint      s;
            t_neuron_out r;
            if (is_bias) begin
                acc   = longint'(w) * 256;
                count = 0;
            end else begin
                acc = acc + longint'(w) * longint'(a);
                if (acc > ACC_HI) acc = ACC_HI;
                if (acc < ACC_LO) acc = ACC_LO;
                if (count < COUNT_CAP) count++;
            end
            if (!is_last) return;
            if (count != fan_in) begin
                r.value      = '0;
                r.size_error = 1'b1;
            end else begin
                s = acc;
                if (s < -WINDOW) s = -WINDOW;
                if (s > WINDOW - 1) s = WINDOW - 1;
                r.value      = sig_lut[int'((s + WINDOW) >>> 10)];
                r.size_error = 1'b0;
            end
            pending_outputs.insert(pending_outputs.size(), r);
            acc   = 0;
            count = 0;
        endfunction

        function void compare_output(logic [nws_pkg::VAL_W-1:0] value, logic size_error);
            t_neuron_out exp_out;
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result: neuron_value %0d size_error %0b",
                         $time, value, size_error);
                errors++;
                return;
            end
            exp_out = pending_outputs.pop_front();
            if (value !== exp_out.value) begin
                $display("%0t: neuron_value mismatch: expected %0d, got %0d",
                         $time, exp_out.value, value);
                errors++;
            end
            if (size_error !== exp_out.size_error) begin
                $display("%0t: size_error mismatch: expected %0b, got %0b",
                         $time, exp_out.size_error, size_error);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n        = 1'b0;
    logic                                i_valid        = 1'b0;
    logic                                o_ready;
    logic signed [nws_pkg::DATA_W-1:0]   i_weight       = '0;
    logic signed [nws_pkg::DATA_W-1:0]   i_activation   = '0;
    logic                                i_is_bias      = 1'b0;
    logic                                i_is_last      = 1'b0;
    logic                                o_valid;
    logic                                i_ready        = 1'b0;
    logic        [nws_pkg::VAL_W-1:0]    o_neuron_value;
    logic                                o_size_error;
    logic                                i_cfg_we       = 1'b0;
    logic        [nws_pkg::CNT_W-1:0]    i_cfg_data     = '0;

    t_neuron_sum_model model = new();
    bit                rst_done    = 1'b0;
    bit                hold_output = 1'b0;
    int                send_calm   = 0;
    int                recv_calm   = 0;
    int                cycle_count = 0;

    neuron_weighted_sum_sigmoid u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_weight       (i_weight),
        .i_activation   (i_activation),
        .i_is_bias      (i_is_bias),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_neuron_value (o_neuron_value),
        .o_size_error   (o_size_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** neuron_weighted_sum_sigmoid: FAILED **");
            $finish;
        end
    end

    // idle cycles before the next transfer; now and then a burst with none
    function automatic int pick_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // mostly values within [-1.0, 1.0] so sums land inside the sigmoid window
    function automatic logic signed [15:0] pick_q88();
        int unsigned r;
        int          reach;
        r = $urandom_range(0, 9);
        if (r == 9) return 16'($urandom);
        reach = (r >= 7) ? 11 : 8;
        return 16'(int'($urandom_range(0, 2 << reach)) - (1 << reach));
    endfunction

    task automatic send_item(input logic signed [15:0] w, input logic signed [15:0] a,
                             input logic is_bias, input logic is_last);
        int idle;
        idle = pick_idle(send_calm);
        @(negedge i_clk);
        if (idle != 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_weight     <= w;
        i_activation <= a;
        i_is_bias    <= is_bias;
        i_is_last    <= is_last;
        do @(posedge i_clk); while (!o_ready);
        model.add_item(w, a, is_bias, is_last);
    endtask

    task automatic send_neuron(input int n, input t_fill fill);
        logic signed [15:0] w;
        logic signed [15:0] a;
        send_item(pick_q88(), pick_q88(), 1'b1, n == 0);
        for (int k = 1; k <= n; k++) begin
            case (fill)
                FILL_POS_PEAK: begin
                    w = 16'sh8000;
                    a = 16'sh8000;
                end
                FILL_NEG_PEAK: begin
                    w = 16'sh7FFF;
                    a = 16'sh8000;
                end
                default: begin
                    w = pick_q88();
                    a = pick_q88();
                end
            endcase
            send_item(w, a, 1'b0, k == n);
        end
    endtask

    // wait out every result, then let non-final items clear the pipeline
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_fan_in(input logic [nws_pkg::CNT_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        model.set_fan_in(v);
    endtask

    task automatic random_phase(input int fan, input int quota);
        int sent;
        int n;
        int r;
        sent = 0;
        write_fan_in(11'(fan));
        while (sent < quota) begin
            r = $urandom_range(0, 19);
            if (r == 18) begin
                // abandoned run: the next bias item restarts the sum
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    send_item(pick_q88(), pick_q88(), k == 0, 1'b0);
                end
                sent += n;
            end else if (r == 19) begin
                send_item(pick_q88(), pick_q88(), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0);
                sent++;
            end else begin
                n = (r < 14) ? fan : $urandom_range(0, fan + 2);
                send_neuron(n, FILL_RANDOM);
                sent += n + 1;
            end
        end
    endtask

    initial begin : result_side
        int idle;
        wait (rst_done);
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                i_ready <= 1'b0;
                repeat (STALL_LEN) @(negedge i_clk);
                hold_output = 1'b0;
            end
            idle = pick_idle(recv_calm);
            if (idle != 0) begin
                i_ready <= 1'b0;
                repeat (idle) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            model.compare_output(o_neuron_value, o_size_error);
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // reset fan-in of 16, no bias item: sum starts from the cleared state
        for (int k = 1; k <= 16; k++) begin
            send_item(pick_q88(), pick_q88(), 1'b0, k == 16);
        end
        send_neuron(16, FILL_RANDOM);

        write_fan_in(11'd2);
        send_item(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);      // bias and last together
        send_item(16'sh0000, 16'sh0000, 1'b1, 1'b0);
        send_item(16'sh8000, 16'sh8000, 1'b0, 1'b0);
        send_item(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);
        send_item(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        send_item(16'sh0000, 16'sh0000, 1'b0, 1'b0);
        send_item(16'sh0000, 16'sh0000, 1'b0, 1'b1);
        send_item(16'sd100,  16'sh5A5A, 1'b1, 1'b0);      // restarted by next bias
        send_item(16'sd5000, 16'sd5000, 1'b0, 1'b0);
        send_item(16'sd0,    16'sh0000, 1'b1, 1'b0);
        send_item(16'sd256,  16'sd256,  1'b0, 1'b0);
        send_item(-16'sd256, 16'sd512,  1'b0, 1'b1);
        send_item(16'sd0,    16'sd0,    1'b1, 1'b0);      // one short
        send_item(16'sd1,    16'sd1,    1'b0, 1'b1);
        send_item(16'sd0,    16'sd0,    1'b1, 1'b0);      // one over
        send_item(16'sd1,    16'sd1,    1'b0, 1'b0);
        send_item(16'sd2,    -16'sd3,   1'b0, 1'b0);
        send_item(16'sd4,    16'sd5,    1'b0, 1'b1);
        send_item(-16'sd2048, 16'sd0,   1'b1, 1'b0);      // sum exactly -8.0
        send_item(16'sd0,    16'sd0,    1'b0, 1'b0);
        send_item(16'sd0,    16'sd0,    1'b0, 1'b1);
        send_item(16'sd2047, 16'sd0,    1'b1, 1'b0);      // sum just below +8.0
        send_item(16'sd255,  16'sd1,    1'b0, 1'b0);
        send_item(16'sd0,    16'sd0,    1'b0, 1'b1);
        send_neuron(2, FILL_NEG_PEAK);                     // far below the window

        write_fan_in(11'd0);
        send_item(16'sd1000, 16'sd0, 1'b1, 1'b1);
        send_item(16'sd3,    16'sd7, 1'b0, 1'b1);

        // stored as 1024; peak products push the accumulator to its upper rail
        write_fan_in(11'd2047);
        send_neuron(1024, FILL_POS_PEAK);

        random_phase(1, PHASE_ITEMS);
        hold_output = 1'b1;
        random_phase(3, PHASE_ITEMS);
        random_phase(0, PHASE_ITEMS);
        random_phase(5, PHASE_ITEMS);
        random_phase(8, PHASE_ITEMS);
        random_phase(2, PHASE_ITEMS);
        random_phase($urandom_range(4, 12), PHASE_ITEMS);
        random_phase(16, PHASE_ITEMS);

        drain();
        repeat (10) @(posedge i_clk);
        if (model.errors == 0 && model.pending() == 0) begin
            $display("** neuron_weighted_sum_sigmoid: PASSED **");
        end else begin
            $display("** neuron_weighted_sum_sigmoid: FAILED **");
        end
        $finish;
    end

endmodule
